### design/assert_macros.svh
// Assertion macros shared by the keyed result table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Condition holds at every clock edge outside reset.
`define KR_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: condition violated");
// Antecedent implies consequent in the same cycle.
`define KR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication violated");
// Antecedent implies consequent in the next cycle.
`define KR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication violated");
`else
`define KR_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define KR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define KR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### design/kr_pkg.sv
// Types and codes shared by the keyed result table modules.
`timescale 1ns / 1ps
`default_nettype none
package kr_pkg;

   localparam int KEY_W     = 16;
   localparam int PAYLOAD_W = 32;
   localparam int STATUS_W  = 2;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_TAKE   = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DUP      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd3;

   // One table slot as stored in memory.
   typedef struct packed {
      logic                 valid;
      logic                 kind;
      logic [KEY_W-1:0]     key_id;
      logic [PAYLOAD_W-1:0] payload;
   } entry_type;

   typedef struct packed {
      logic                 req_type;
      logic [KEY_W-1:0]     key_id;
      logic                 entry_kind;
      logic [PAYLOAD_W-1:0] entry_payload;
   } req_item_type;

   typedef struct packed {
      logic                 valid;
      logic [STATUS_W-1:0]  status;
      logic [PAYLOAD_W-1:0] payload_out;
   } result_type;

endpackage
`default_nettype wire

### design/kr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module kr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### design/kr_engine.sv
// Scan sequencer: clears slots after reset; then scans/updates per request.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module kr_engine #(
   parameter int TABLE_DEPTH = 256
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire kr_pkg::req_item_type req,
   output logic                      req_ready,
   output kr_pkg::result_type        res,
   input  wire logic                 res_ready
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);
   localparam int EW = $bits(kr_pkg::entry_type);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic          issue_done_ff, issue_done_in;
   logic          chk_valid_ff, chk_valid_in;
   logic [AW-1:0] chk_addr_ff, chk_addr_in;
   logic [AW-1:0] free_ff, free_in;
   logic          have_free_ff, have_free_in;
   logic [CW-1:0] count_ff, count_in;
   kr_pkg::req_item_type req_ff, req_in;
   logic [kr_pkg::STATUS_W-1:0]  stat_ff, stat_in;
   logic [kr_pkg::PAYLOAD_W-1:0] pout_ff, pout_in;

   logic              ram_we, ram_re;
   logic [AW-1:0]     ram_waddr;
   kr_pkg::entry_type ram_wdata, rd_entry;
   logic [EW-1:0]     ram_rdata;

   logic          id_hit, have_now;
   logic [AW-1:0] free_now;

   kr_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ptr_ff),
      .rd_data (ram_rdata)
   );

   assign rd_entry = kr_pkg::entry_type'(ram_rdata);
   assign id_hit   = rd_entry.valid && (rd_entry.key_id == req_ff.key_id);
   assign have_now = have_free_ff || !rd_entry.valid;
   assign free_now = rd_entry.valid ? free_ff : chk_addr_ff;

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      issue_done_in = issue_done_ff;
      chk_valid_in  = chk_valid_ff;
      chk_addr_in   = chk_addr_ff;
      free_in       = free_ff;
      have_free_in  = have_free_ff;
      count_in      = count_ff;
      req_in        = req_ff;
      stat_in       = stat_ff;
      pout_in       = pout_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_waddr     = chk_addr_ff;
      ram_wdata     = '0;

      unique case (state_ff)
         S_CLEAR: begin
            // Sweep every slot to invalid, one per cycle.
            ram_we    = 1'b1;
            ram_waddr = ptr_ff;
            ptr_in    = ptr_ff + 1'b1;
            if (ptr_ff == LAST_ADDR) begin
               ptr_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in  = req;
               pout_in = '0;
               if (req.req_type == kr_pkg::REQ_INSERT && count_ff >= FULL_COUNT) begin
                  stat_in  = kr_pkg::STATUS_FULL;
                  state_in = S_DONE;
               end else begin
                  ptr_in        = '0;
                  issue_done_in = 1'b0;
                  chk_valid_in  = 1'b0;
                  have_free_in  = 1'b0;
                  state_in      = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // Issue one read per cycle; check the previous read's data.
            if (!issue_done_ff) begin
               ram_re       = 1'b1;
               chk_valid_in = 1'b1;
               chk_addr_in  = ptr_ff;
               ptr_in       = ptr_ff + 1'b1;
               if (ptr_ff == LAST_ADDR) begin
                  issue_done_in = 1'b1;
               end
            end else begin
               chk_valid_in = 1'b0;
            end
            if (chk_valid_ff) begin
               if (req_ff.req_type == kr_pkg::REQ_INSERT) begin
                  free_in      = free_now;
                  have_free_in = have_now;
                  if (id_hit) begin
                     stat_in  = kr_pkg::STATUS_DUP;
                     state_in = S_DONE;
                  end else if (chk_addr_ff == LAST_ADDR) begin
                     state_in = S_DONE;
                     if (have_now) begin
                        ram_we            = 1'b1;
                        ram_waddr         = free_now;
                        ram_wdata.valid   = 1'b1;
                        ram_wdata.kind    = req_ff.entry_kind;
                        ram_wdata.key_id  = req_ff.key_id;
                        ram_wdata.payload = req_ff.entry_payload;
                        count_in          = count_ff + 1'b1;
                        stat_in           = kr_pkg::STATUS_OK;
                     end else begin
                        stat_in = kr_pkg::STATUS_FULL;
                     end
                  end
               end else begin
                  if (id_hit && rd_entry.kind == req_ff.entry_kind) begin
                     // Free the slot: write it back invalid.
                     ram_we    = 1'b1;
                     ram_waddr = chk_addr_ff;
                     pout_in   = rd_entry.payload;
                     stat_in   = kr_pkg::STATUS_OK;
                     if (count_ff != '0) begin
                        count_in = count_ff - 1'b1;
                     end
                     state_in = S_DONE;
                  end else if (chk_addr_ff == LAST_ADDR) begin
                     stat_in  = kr_pkg::STATUS_NOTFOUND;
                     state_in = S_DONE;
                  end
               end
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         ptr_ff        <= '0;
         issue_done_ff <= 1'b0;
         chk_valid_ff  <= 1'b0;
         have_free_ff  <= 1'b0;
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         issue_done_ff <= issue_done_in;
         chk_valid_ff  <= chk_valid_in;
         have_free_ff  <= have_free_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_addr_ff <= chk_addr_in;
      free_ff     <= free_in;
      req_ff      <= req_in;
      stat_ff     <= stat_in;
      pout_ff     <= pout_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign res.valid       = (state_ff == S_DONE);
   assign res.status      = stat_ff;
   assign res.payload_out = pout_ff;

   `KR_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= FULL_COUNT)
   `KR_ASSERT_IMP(a_write_state, clock, reset, ram_we, state_ff == S_CLEAR || state_ff == S_SCAN)
   `KR_ASSERT_NEXT(a_accept_moves, clock, reset, req_valid && req_ready, state_ff != S_IDLE)
   `KR_ASSERT_NEXT(a_count_step, clock, reset, state_ff != S_SCAN, $stable(count_ff))

endmodule
`default_nettype wire

### design/keyed_result_table.sv
// Keyed result table: insert/take requests against a memory of keyed slots.
// Requests: a full scan reads every slot before the response; a take or duplicate that
//   hits slot i ends the scan at that slot; an insert into a full table skips the scan.
// One request at a time: a new request is accepted only after the previous result has moved
//   into the output register; the scan reads the slot memory one slot per cycle.
// Reset: synchronous; then a clearing pass that invalidates every slot, with req_tready low.
`timescale 1ns / 1ps
`default_nettype none
module keyed_result_table #(
   parameter int TABLE_DEPTH = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,  // [15:0] key_id, [16] entry_kind,
                                        // [48:17] entry_payload, [55:49] zero
   input  wire logic        req_tuser,  // [0] req_type
   // Response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata   // [1:0] status, [33:2] payload_out, [39:34] zero
);

   kr_pkg::req_item_type req;
   kr_pkg::result_type   res;
   logic                 res_ready;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [kr_pkg::STATUS_W-1:0]      rsp_status_ff;
   logic [kr_pkg::PAYLOAD_W-1:0]     rsp_payload_ff;

   // Unpack the request transfer.
   assign req.req_type      = req_tuser;
   assign req.key_id        = req_tdata[15:0];
   assign req.entry_kind    = req_tdata[16];
   assign req.entry_payload = req_tdata[48:17];

   kr_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req       (req),
      .req_ready (req_tready),
      .res       (res),
      .res_ready (res_ready)
   );

   // Output register: take a new result when empty or being drained this cycle.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_ready) begin
         rsp_valid_in = res.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload while stalled; load on a fresh result.
   always_ff @(posedge clock) begin
      if (res_ready && res.valid) begin
         rsp_status_ff  <= res.status;
         rsp_payload_ff <= res.payload_out;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_payload_ff, rsp_status_ff};

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for keyed_result_table: directed, fill-to-capacity and random traffic.
`timescale 1ns / 1ps
module testbench;

   localparam int TABLE_DEPTH  = 256;
   localparam int RANDOM_ITEMS = 1450;
   localparam int KEY_W        = kr_pkg::KEY_W;
   localparam int PAYLOAD_W    = kr_pkg::PAYLOAD_W;
   localparam int STATUS_W     = kr_pkg::STATUS_W;
   // Slowest legal item: full scan, longest receiver stall, longest sender gap.
   // Take that over every item, then several times over, plus the clearing pass.
   localparam int CYCLE_LIMIT  = 8000000;

   // One expected answer of the table: status code and returned payload.
   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [PAYLOAD_W-1:0] payload;
   } table_answer_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;   // [15:0] key_id, [16] entry_kind, [48:17] entry_payload, [55:49] zero
   logic        req_tuser;   // [0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [1:0] status, [33:2] payload_out, [39:34] zero

   // Shadow copy of the table, updated as each request transfer is accepted.
   logic                 held_live    [TABLE_DEPTH];
   logic [KEY_W-1:0]     held_key     [TABLE_DEPTH];
   logic                 held_kind    [TABLE_DEPTH];
   logic [PAYLOAD_W-1:0] held_payload [TABLE_DEPTH];
   int                   held_total;

   table_answer_type awaited_answers[$];
   int               mismatch_count;
   int               burst_left;
   int               cycle_count;

   keyed_result_table #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: end the run if the traffic never completes.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("keyed_result_table: mismatch");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Compute the table's answer to one request and apply its side effects to the shadow copy.
   // Insert: full check first, then duplicate id over every live slot (kind ignored), then
   // the highest-numbered free slot. Take: lowest-numbered live slot matching id and kind.
   function automatic table_answer_type predict_table_answer(input kr_pkg::req_item_type r);
      table_answer_type ans;
      int               free_slot;
      ans.status  = kr_pkg::STATUS_OK;
      ans.payload = '0;
      free_slot   = -1;
      if (r.req_type == kr_pkg::REQ_INSERT) begin
         if (held_total >= TABLE_DEPTH) begin
            ans.status = kr_pkg::STATUS_FULL;
         end else begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (!held_live[i]) begin
                  free_slot = i;
               end else if (held_key[i] == r.key_id) begin
                  ans.status = kr_pkg::STATUS_DUP;
               end
            end
            if (ans.status == kr_pkg::STATUS_OK) begin
               if (free_slot < 0) begin
                  ans.status = kr_pkg::STATUS_FULL;
               end else begin
                  held_live[free_slot]    = 1'b1;
                  held_key[free_slot]     = r.key_id;
                  held_kind[free_slot]    = r.entry_kind;
                  held_payload[free_slot] = r.entry_payload;
                  held_total++;
               end
            end
         end
      end else begin
         ans.status = kr_pkg::STATUS_NOTFOUND;
         for (int i = 0; i < TABLE_DEPTH && ans.status == kr_pkg::STATUS_NOTFOUND; i++) begin
            if (held_live[i] && held_key[i] == r.key_id && held_kind[i] == r.entry_kind) begin
               ans.status   = kr_pkg::STATUS_OK;
               ans.payload  = held_payload[i];
               held_live[i] = 1'b0;
               if (held_total > 0) held_total--;
            end
         end
      end
      return ans;
   endfunction

   function automatic kr_pkg::req_item_type make_request(input logic op,
                                                         input logic [KEY_W-1:0] key,
                                                         input logic kind,
                                                         input logic [PAYLOAD_W-1:0] payload);
      kr_pkg::req_item_type r;
      r.req_type      = op;
      r.key_id        = key;
      r.entry_kind    = kind;
      r.entry_payload = payload;
      return r;
   endfunction

   // Only call while at least one slot is live.
   function automatic int any_live_slot();
      int s;
      do s = $urandom_range(0, TABLE_DEPTH - 1); while (!held_live[s]);
      return s;
   endfunction

   // A key that no live entry holds.
   function automatic logic [KEY_W-1:0] fresh_key();
      logic [KEY_W-1:0] k;
      logic             taken;
      do begin
         k     = KEY_W'($urandom_range(0, 65535));
         taken = 1'b0;
         for (int i = 0; i < TABLE_DEPTH; i++)
            if (held_live[i] && held_key[i] == k) taken = 1'b1;
      end while (taken);
      return k;
   endfunction

   // Random request; insert_pct steers the table toward growing or shrinking.
   // Most takes hit a live entry; the rest miss on kind or on a random id.
   function automatic kr_pkg::req_item_type random_request(input int insert_pct);
      int s;
      int pick;
      if ($urandom_range(0, 99) < insert_pct) begin
         if (held_total > 0 && $urandom_range(0, 5) == 0) begin
            s = any_live_slot();
            return make_request(kr_pkg::REQ_INSERT, held_key[s], 1'($urandom), $urandom);
         end
         return make_request(kr_pkg::REQ_INSERT, KEY_W'($urandom_range(0, 65535)),
                             1'($urandom), $urandom);
      end
      pick = $urandom_range(0, 9);
      if (held_total > 0 && pick < 6) begin
         s = any_live_slot();
         return make_request(kr_pkg::REQ_TAKE, held_key[s], held_kind[s], $urandom);
      end
      if (held_total > 0 && pick < 8) begin
         s = any_live_slot();
         return make_request(kr_pkg::REQ_TAKE, held_key[s], ~held_kind[s], $urandom);
      end
      return make_request(kr_pkg::REQ_TAKE, KEY_W'($urandom_range(0, 65535)), 1'($urandom),
                          $urandom);
   endfunction

   // Send one request. Bursts of random length; between most bursts, drop tvalid for a gap that
   // is usually short and now and then spans a whole scan. Record the answer on transfer.
   task automatic transfer_request(input kr_pkg::req_item_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 3) == 0) gap = 0;
         else if ($urandom_range(0, 7) == 0) gap = $urandom_range(1, 300);
         else gap = $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= r.req_type;
      req_tdata  <= {7'b0, r.entry_payload, r.entry_kind, r.key_id};
      do @(posedge clock); while (req_tready !== 1'b1);
      awaited_answers.push_back(predict_table_answer(r));
   endtask

   // Drop tvalid and hold off until every awaited answer has arrived.
   task automatic await_all_answers();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (awaited_answers.size() != 0) @(posedge clock);
   endtask

   // Extremes of id and payload, duplicate across kinds, kind mismatch, reuse of a freed
   // slot, and takes on an empty table.
   task automatic test_directed_cases();
      transfer_request(make_request(kr_pkg::REQ_TAKE,   16'h0000, 1'b0, 32'h0000_0000));
      transfer_request(make_request(kr_pkg::REQ_INSERT, 16'h0000, 1'b0, 32'h0000_0000));
      transfer_request(make_request(kr_pkg::REQ_INSERT, 16'hFFFF, 1'b1, 32'hFFFF_FFFF));
      transfer_request(make_request(kr_pkg::REQ_INSERT, 16'h0000, 1'b1, 32'h0000_1234));
      transfer_request(make_request(kr_pkg::REQ_INSERT, 16'hFFFF, 1'b1, 32'h0BAD_F00D));
      transfer_request(make_request(kr_pkg::REQ_TAKE,   16'h0000, 1'b1, 32'h0000_0000));
      transfer_request(make_request(kr_pkg::REQ_TAKE,   16'hFFFF, 1'b0, 32'h0000_0000));
      transfer_request(make_request(kr_pkg::REQ_INSERT, 16'hA5A5, 1'b0, 32'hA5A5_A5A5));
      transfer_request(make_request(kr_pkg::REQ_INSERT, 16'h5A5A, 1'b1, 32'h5A5A_5A5A));
      transfer_request(make_request(kr_pkg::REQ_TAKE,   16'hFFFF, 1'b1, 32'hDEAD_BEEF));
      transfer_request(make_request(kr_pkg::REQ_TAKE,   16'hFFFF, 1'b1, 32'hFFFF_FFFF));
      transfer_request(make_request(kr_pkg::REQ_INSERT, 16'hFFFF, 1'b0, 32'h8000_0001));
      transfer_request(make_request(kr_pkg::REQ_TAKE,   16'h0000, 1'b0, 32'h0000_0000));
      transfer_request(make_request(kr_pkg::REQ_TAKE,   16'h5A5A, 1'b1, 32'h0000_0000));
      transfer_request(make_request(kr_pkg::REQ_TAKE,   16'hA5A5, 1'b0, 32'h0000_0000));
      transfer_request(make_request(kr_pkg::REQ_TAKE,   16'hFFFF, 1'b0, 32'h0000_0000));
      transfer_request(make_request(kr_pkg::REQ_TAKE,   16'h1234, 1'b1, 32'h0000_0000));
   endtask

   // Fill every slot, hit the full table (a duplicate id too), refill one freed slot,
   // then empty the table in random order with some kind misses.
   task automatic test_fill_to_capacity();
      int s;
      while (held_total < TABLE_DEPTH)
         transfer_request(make_request(kr_pkg::REQ_INSERT, fresh_key(), 1'($urandom), $urandom));
      transfer_request(make_request(kr_pkg::REQ_INSERT, fresh_key(), 1'($urandom), $urandom));
      s = any_live_slot();
      transfer_request(make_request(kr_pkg::REQ_INSERT, held_key[s], held_kind[s], $urandom));
      s = any_live_slot();
      transfer_request(make_request(kr_pkg::REQ_TAKE, held_key[s], held_kind[s], $urandom));
      transfer_request(make_request(kr_pkg::REQ_INSERT, fresh_key(), 1'($urandom), $urandom));
      transfer_request(make_request(kr_pkg::REQ_INSERT, fresh_key(), 1'($urandom), $urandom));
      while (held_total > 0) begin
         s = any_live_slot();
         if ($urandom_range(0, 7) == 0)
            transfer_request(make_request(kr_pkg::REQ_TAKE, held_key[s], ~held_kind[s],
                                          $urandom));
         else
            transfer_request(make_request(kr_pkg::REQ_TAKE, held_key[s], held_kind[s],
                                          $urandom));
      end
      transfer_request(make_request(kr_pkg::REQ_TAKE, 16'hFFFF, 1'b1, $urandom));
   endtask

   // Segments that grow, shrink or hold the table level, so the count wanders across
   // its range; drain once midway.
   task automatic test_random_traffic();
      int  sent;
      int  seg_len;
      int  insert_pct;
      bit  drained;
      sent    = 0;
      drained = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 2))
            0: insert_pct = 85;
            1: insert_pct = 15;
            default: insert_pct = 50;
         endcase
         seg_len = $urandom_range(60, 300);
         repeat (seg_len) begin
            transfer_request(random_request(insert_pct));
            sent++;
         end
         if (!drained && sent >= RANDOM_ITEMS / 2) begin
            await_all_answers();
            drained = 1'b1;
         end
      end
   endtask

   // Receiver: runs of ready and stall, mostly short, sometimes long either way.
   initial begin
      int run_left;
      int pick;
      rsp_tready <= 1'b0;
      run_left = 0;
      forever begin
         @(negedge clock);
         if (run_left == 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               rsp_tready <= 1'b1;
               run_left = $urandom_range(1, 40);
            end else if (pick == 6) begin
               rsp_tready <= 1'b1;
               run_left = $urandom_range(200, 1500);
            end else if (pick < 9) begin
               rsp_tready <= 1'b0;
               run_left = $urandom_range(1, 6);
            end else begin
               rsp_tready <= 1'b0;
               run_left = $urandom_range(20, 300);
            end
         end
         run_left--;
      end
   end

   // Compare each response transfer with the oldest awaited answer.
   always @(posedge clock) begin
      table_answer_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (awaited_answers.size() == 0) begin
            report_mismatch("response with no request pending", 32'(rsp_tdata[33:2]), 32'h0);
         end else begin
            want = awaited_answers.pop_front();
            if (rsp_tdata[1:0] !== want.status)
               report_mismatch("status", 32'(rsp_tdata[1:0]), 32'(want.status));
            if (rsp_tdata[33:2] !== want.payload)
               report_mismatch("payload_out", rsp_tdata[33:2], want.payload);
         end
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= 1'b0;
      req_tdata  <= '0;
      mismatch_count = 0;
      burst_left     = 0;
      held_total     = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) held_live[i] = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      await_all_answers();
      test_fill_to_capacity();
      await_all_answers();
      test_random_traffic();
      await_all_answers();

      // Allow one more full scan for any stray response.
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      if (mismatch_count == 0 && awaited_answers.size() == 0) begin
         $display("keyed_result_table: match");
      end else begin
         $display("keyed_result_table: mismatch");
      end
      $finish;
   end

endmodule
